// File: src/mmio_command_queue_assert.svh
// ---------------------------------------------------------------------------
// mmio_command_queue assertion macros
// Shorthand for clocked assertions with reset disable, same-cycle or next-cycle
// ---------------------------------------------------------------------------
`ifndef MMIO_COMMAND_QUEUE_ASSERT_SVH
`define MMIO_COMMAND_QUEUE_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MCQ_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MCQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/mcq_pkg.sv
// ---------------------------------------------------------------------------
// mcq_pkg
// Codes, constants and helpers of the memory-mapped command queue
// ---------------------------------------------------------------------------
`default_nettype none

package mcq_pkg;

  // default sizing
  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int CMD_BYTES_DEF   = 32;

  // input command codes
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_RETRY = 2'd1;
  localparam logic [1:0] STS_ERROR = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_BEAT   = 1'b1;

  // largest legal access size in bytes
  localparam logic [3:0] MAX_SIZE = 4'd8;

  // downstream address pattern
  localparam logic [30:0] DISPATCH_BASE = 31'h7000_0000;
  localparam logic [3:0]  NIBBLE        = 4'hF;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_EXEC,
    S_STG_LO,
    S_STG_HI,
    S_PUSH,
    S_STATUS,
    S_DISP
  } state_t;

  // downstream address from the first command word
  function automatic logic [30:0] dispatch_target(input logic [63:0] w);
    return DISPATCH_BASE
         | (31'(w[27:24] & NIBBLE) << 24)
         | (31'(w[23:20] & NIBBLE) << 20);
  endfunction

  // byte lane enables for an access of sz bytes (1 to 8)
  function automatic logic [7:0] size_lanes(input logic [3:0] sz);
    logic [8:0] one_hot;
    one_hot = 9'd1 << sz;
    return 8'(one_hot - 9'd1);
  endfunction

  // expand byte lane enables to a bit mask
  function automatic logic [63:0] lane_mask(input logic [7:0] be);
    logic [63:0] m;
    m = '0;
    for (int l = 0; l < 8; l++) begin
      m[8*l +: 8] = {8{be[l]}};
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// File: src/mmio_command_queue.sv
// ---------------------------------------------------------------------------
// mmio_command_queue
// Command queue fed through a memory-mapped window, dispatched downstream
// ---------------------------------------------------------------------------
// Usage: an input word (command, address, size, data) is taken when start is
// high and busy is low. Bus writes to the data half of the window, at the
// window base, land in a staging buffer; writes of 0 / 1 to the control half
// push the staging buffer into the queue / drop the head. A tick reopens the
// push gate, a completion retires the command in flight.
// Each word yields one status result, then, when it starts a dispatch, one
// 64-bit beat per eight command bytes. Results sit on the out_ ports for one
// cycle with out_valid high; the receiver cannot stall them.
// Steps: accept, decode, execute, then the status result. A staging write
// adds S_STG_LO, and S_STG_HI when it touches a second row of the staging
// memory; a push adds S_PUSH for the row copy from the staging memory to
// the queue memory, and a dispatch adds S_DISP, one queue memory read per
// beat. Only one word is in progress at a time, so reads and writes of the
// same memory row never overlap.
// Reset: queue empty, staging buffer zero (row valid bits), push gate open,
// nothing in flight, window base zero. cfg_we writes the window base at once.
// ---------------------------------------------------------------------------
`default_nettype none

module mmio_command_queue
  import mcq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int CMD_BYTES   = CMD_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  // input word
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_command,
  input  wire logic [31:0] in_address,
  input  wire logic [3:0]  in_size,
  input  wire logic [63:0] in_data,
  // results
  output logic             out_valid,
  output logic             out_kind,
  output logic [1:0]       out_status,
  output logic [30:0]      out_dest_addr,
  output logic [63:0]      out_beat_data,
  output logic             out_last,
  output logic [3:0]       out_occupancy,
  output logic             out_push_ready
);

  localparam int BEATS   = (CMD_BYTES + 7) / 8;
  localparam int SROW_W  = (BEATS > 1) ? $clog2(BEATS) : 1;
  localparam int OFF_W   = SROW_W + 3;
  localparam int BCNT_W  = $clog2(BEATS + 1);
  localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int QWORDS  = QUEUE_DEPTH * BEATS;
  localparam int QA_W    = (QWORDS > 1) ? $clog2(QWORDS) : 1;

  // control state
  state_t               state_r, state_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt;
  logic [PTR_W-1:0]     tail_r, tail_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 gate_r, gate_nxt;
  logic                 dbusy_r, dbusy_nxt;
  logic                 disp_r, disp_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [BCNT_W-1:0]    cnt_r, cnt_nxt;
  logic [QA_W-1:0]      push_base_r, push_base_nxt;
  logic [31:0]          win_base_r;
  logic [BEATS-1:0]     stg_vld_r;

  // payload registers
  logic [1:0]           cmd_r;
  logic [31:0]          addr_r;
  logic [3:0]           size_r;
  logic [63:0]          data_r;
  logic                 lt_base_r;
  logic [31:0]          off_r;
  logic [7:0]           be8_r;
  logic                 val_zero_r;
  logic                 val_one_r;
  logic [30:0]          target_r;

  // memories
  logic [63:0]          stg_mem [BEATS];
  logic [63:0]          q_mem [QWORDS];
  logic [63:0]          stg_rdata_r;
  logic                 stg_rvld_r;
  logic [63:0]          q_rdata_r;

  // memory control
  logic                 stg_we;
  logic [SROW_W-1:0]    stg_row;
  logic [63:0]          stg_wdata;
  logic [7:0]           stg_be;
  logic                 stg_re;
  logic                 stg_clear;
  logic                 q_we;
  logic [QA_W-1:0]      q_waddr;
  logic                 q_re;
  logic [QA_W-1:0]      q_raddr;

  // helpers
  logic                 accept;
  logic [127:0]         stg_wide;
  logic [15:0]          stg_be16;
  logic [SROW_W-1:0]    row_lo;
  logic [QA_W-1:0]      head_base;
  logic                 can_push;
  logic                 win_bad;
  logic [32:0]          off_end;
  logic [BCNT_W-1:0]    last_beat;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign can_push  = (count_r < CNT_W'(QUEUE_DEPTH)) && !gate_r;
  assign head_base = QA_W'(32'(head_r) * 32'(BEATS));
  assign last_beat = BCNT_W'(BEATS - 1);
  assign off_end   = {1'b0, off_r} + 33'(size_r);
  assign win_bad   = lt_base_r || (size_r == 4'd0) || (size_r > MAX_SIZE)
                  || ({1'b0, off_r} >= 33'(2 * CMD_BYTES))
                  || (off_end > 33'(2 * CMD_BYTES));

  // staging write data placed at its byte lanes, over two rows
  assign stg_wide = 128'(data_r & lane_mask(be8_r)) << {off_r[2:0], 3'b000};
  assign stg_be16 = 16'(be8_r) << off_r[2:0];
  assign row_lo   = off_r[OFF_W-1:3];

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_base_r <= '0;
    end else if (cfg_we) begin
      win_base_r <= cfg_wdata;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      gate_r      <= 1'b0;
      dbusy_r     <= 1'b0;
      disp_r      <= 1'b0;
      status_r    <= STS_OK;
      cnt_r       <= '0;
      push_base_r <= '0;
      stg_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      gate_r      <= gate_nxt;
      dbusy_r     <= dbusy_nxt;
      disp_r      <= disp_nxt;
      status_r    <= status_nxt;
      cnt_r       <= cnt_nxt;
      push_base_r <= push_base_nxt;
      if (stg_clear) begin
        stg_vld_r <= '0;
      end else if (stg_we) begin
        stg_vld_r[stg_row] <= 1'b1;
      end
    end
  end

  // input capture and decode registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_command;
      addr_r <= in_address;
      size_r <= in_size;
      data_r <= in_data;
    end
    if (state_r == S_DECODE) begin
      lt_base_r  <= addr_r < win_base_r;
      off_r      <= addr_r - win_base_r;
      be8_r      <= size_lanes(size_r);
      val_zero_r <= (data_r & lane_mask(size_lanes(size_r))) == 64'd0;
      val_one_r  <= (data_r & lane_mask(size_lanes(size_r))) == 64'd1;
    end
    if (state_r == S_DISP && cnt_r == '0) begin
      target_r <= dispatch_target(q_rdata_r);
    end
  end

  // staging memory: byte-lane writes, rows not yet valid fill with zeros
  always_ff @(posedge clk) begin
    if (stg_we) begin
      for (int l = 0; l < 8; l++) begin
        if (stg_be[l] || !stg_vld_r[stg_row]) begin
          stg_mem[stg_row][8*l +: 8] <= stg_be[l] ? stg_wdata[8*l +: 8] : 8'h00;
        end
      end
    end
    if (stg_re) begin
      stg_rdata_r <= stg_mem[cnt_r[SROW_W-1:0]];
      stg_rvld_r  <= stg_vld_r[cnt_r[SROW_W-1:0]];
    end
  end

  // queue memory
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[q_waddr] <= stg_rvld_r ? stg_rdata_r : 64'd0;
    end
    if (q_re) begin
      q_rdata_r <= q_mem[q_raddr];
    end
  end

  // next state and memory control
  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    gate_nxt      = gate_r;
    dbusy_nxt     = dbusy_r;
    disp_nxt      = disp_r;
    status_nxt    = status_r;
    cnt_nxt       = cnt_r;
    push_base_nxt = push_base_r;
    stg_we        = 1'b0;
    stg_row       = row_lo;
    stg_wdata     = stg_wide[63:0];
    stg_be        = stg_be16[7:0];
    stg_re        = 1'b0;
    stg_clear     = 1'b0;
    q_we          = 1'b0;
    q_waddr       = QA_W'(32'(push_base_r) + 32'(cnt_r) - 32'd1);
    q_re          = 1'b0;
    q_raddr       = head_base;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        state_nxt = S_EXEC;
      end

      S_EXEC: begin
        status_nxt = STS_OK;
        state_nxt  = S_STATUS;
        cnt_nxt    = '0;
        case (cmd_r)
          CMD_WRITE: begin
            if (win_bad) begin
              status_nxt = STS_RETRY;
            end else if (off_r < 32'(CMD_BYTES)) begin
              // data half
              if (off_end > 33'(CMD_BYTES)) begin
                status_nxt = STS_RETRY;
              end else begin
                state_nxt = S_STG_LO;
              end
            end else if (val_zero_r) begin
              // push request
              if (can_push) begin
                tail_nxt      = ptr_inc(tail_r);
                count_nxt     = count_r + 1'b1;
                gate_nxt      = 1'b1;
                push_base_nxt = QA_W'(32'(tail_r) * 32'(BEATS));
                state_nxt     = S_PUSH;
              end else begin
                status_nxt = STS_RETRY;
              end
            end else if (val_one_r) begin
              // pop request
              if (count_r == '0) begin
                status_nxt = STS_ERROR;
              end else begin
                head_nxt  = ptr_inc(head_r);
                count_nxt = count_r - 1'b1;
              end
            end else begin
              status_nxt = STS_RETRY;
            end
          end
          CMD_READ: begin
            status_nxt = STS_RETRY;
          end
          CMD_DONE: begin
            if (!dbusy_r || count_r == '0) begin
              status_nxt = STS_ERROR;
            end else begin
              head_nxt  = ptr_inc(head_r);
              count_nxt = count_r - 1'b1;
              dbusy_nxt = 1'b0;
            end
          end
          CMD_TICK: begin
            gate_nxt = 1'b0;
          end
          default: begin
            status_nxt = STS_RETRY;
          end
        endcase
        // start a dispatch when idle downstream and a command is queued
        disp_nxt = !dbusy_nxt && (count_nxt != '0);
        if (disp_nxt) begin
          dbusy_nxt = 1'b1;
        end
      end

      S_STG_LO: begin
        stg_we = 1'b1;
        if (stg_be16[15:8] != 8'h00) begin
          state_nxt = S_STG_HI;
        end else begin
          state_nxt = S_STATUS;
        end
      end

      S_STG_HI: begin
        stg_we    = 1'b1;
        stg_row   = row_lo + 1'b1;
        stg_wdata = stg_wide[127:64];
        stg_be    = stg_be16[15:8];
        state_nxt = S_STATUS;
      end

      // copy staging rows into the queue entry, one row a cycle
      S_PUSH: begin
        stg_re  = (cnt_r < BCNT_W'(BEATS));
        q_we    = (cnt_r != '0);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == BCNT_W'(BEATS)) begin
          stg_clear = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_STATUS;
        end
      end

      S_STATUS: begin
        q_re    = disp_r;
        cnt_nxt = '0;
        if (disp_r) begin
          state_nxt = S_DISP;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // one beat a cycle, next read issued alongside
      S_DISP: begin
        q_re    = (cnt_r != last_beat);
        q_raddr = QA_W'(32'(head_base) + 32'(cnt_r) + 32'd1);
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == last_beat) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // result ports
  always_comb begin
    out_valid       = (state_r == S_STATUS) || (state_r == S_DISP);
    out_kind        = (state_r == S_DISP) ? KIND_BEAT : KIND_STATUS;
    out_status      = (state_r == S_STATUS) ? status_r : STS_OK;
    out_dest_addr   = '0;
    out_beat_data   = '0;
    out_last        = 1'b0;
    if (state_r == S_STATUS) begin
      out_last = !disp_r;
    end
    if (state_r == S_DISP) begin
      out_dest_addr   = (cnt_r == '0) ? dispatch_target(q_rdata_r) : target_r;
      out_beat_data   = q_rdata_r;
      out_last        = (cnt_r == last_beat);
    end
    out_occupancy  = 4'(count_r);
    out_push_ready = can_push;
  end

  // checks
`include "mmio_command_queue_assert.svh"

  `MCQ_ASSERT_SAME(a_count_range, 1'b1, count_r <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `MCQ_ASSERT_SAME(a_beat_in_flight, out_valid && out_kind == KIND_BEAT, dbusy_r, "beat without dispatch in flight")
  `MCQ_ASSERT_NEXT(a_status_then_beat, out_valid && out_kind == KIND_STATUS && !out_last, out_valid && out_kind == KIND_BEAT, "dispatch did not follow status")
  `MCQ_ASSERT_NEXT(a_last_ends_word, out_valid && out_last, !out_valid && !busy, "result after last of a word")

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: mmio_command_queue regression
// Drives bus words through the command window and checks every status result
// and dispatch beat against a cycle-free model of the queue, over several
// window base settings and sender idle rates
// ---------------------------------------------------------------------------

module tb;
  import mcq_pkg::*;

  localparam int QDEPTH = QUEUE_DEPTH_DEF;
  localparam int BEATS = CMD_BYTES_DEF / 8;
  localparam int CTL = CMD_BYTES_DEF;
  localparam logic [31:0] WIN_BYTES = 32'(2 * CMD_BYTES_DEF);
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 30;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [30:0] target;
    logic [63:0] beat;
    logic        last;
    logic [3:0]  occ;
    logic        push_rdy;
  } reply_t;

  // dut ports
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = CMD_TICK;
  logic [31:0] in_address = '0;
  logic [3:0]  in_size = '0;
  logic [63:0] in_data = '0;
  logic        out_valid;
  logic        out_kind;
  logic [1:0]  out_status;
  logic [30:0] out_dest_addr;
  logic [63:0] out_beat_data;
  logic        out_last;
  logic [3:0]  out_occupancy;
  logic        out_push_ready;

  // queue model state
  logic [7:0]  stg_byte [CMD_BYTES_DEF];
  logic [63:0] cmdq_word [QDEPTH][BEATS];
  logic [2:0]  hd = '0;
  logic [2:0]  tl = '0;
  logic [3:0]  cnt = '0;
  logic        gate_shut = 1'b0;
  logic        in_flight = 1'b0;
  logic [31:0] win_base = '0;

  reply_t replies_due[$];

  int idle_pct = 0;
  int err_cnt = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_push = 0;
  int n_disp = 0;
  int n_retry = 0;
  int n_error = 0;
  int stall_cnt = 0;

  mmio_command_queue dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_command     (in_command),
    .in_address     (in_address),
    .in_size        (in_size),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_status     (out_status),
    .out_dest_addr  (out_dest_addr),
    .out_beat_data  (out_beat_data),
    .out_last       (out_last),
    .out_occupancy  (out_occupancy),
    .out_push_ready (out_push_ready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // apply one accepted word to the model and queue the results it causes
  task automatic compute_replies(input logic [1:0] cmd, input logic [31:0] addr,
                                 input logic [3:0] sz, input logic [63:0] d);
    logic [1:0]  sts;
    logic [31:0] off;
    logic [63:0] val;
    logic [30:0] tgt;
    logic        disp;
    reply_t      r;
    sts = STS_OK;
    off = addr - win_base;
    case (cmd)
      CMD_WRITE: begin
        if (addr < win_base || sz == 4'd0 || sz > MAX_SIZE ||
            off >= WIN_BYTES || off + sz > WIN_BYTES) begin
          sts = STS_RETRY;
        end else if (off < CTL) begin
          // data half: little-endian bytes into staging
          if (off + sz > CTL) sts = STS_RETRY;
          else for (int i = 0; i < sz; i++) stg_byte[off + i] = d[8*i +: 8];
        end else begin
          // control half: only the low size bytes count
          val = (sz == MAX_SIZE) ? d : d & ((64'd1 << (8 * sz)) - 64'd1);
          if (val == 64'd0) begin
            if (cnt >= QDEPTH || gate_shut) begin
              sts = STS_RETRY;
            end else begin
              for (int w = 0; w < BEATS; w++)
                for (int b = 0; b < 8; b++) cmdq_word[tl][w][8*b +: 8] = stg_byte[8*w + b];
              for (int k = 0; k < CMD_BYTES_DEF; k++) stg_byte[k] = 8'h00;
              tl = tl + 3'd1;
              cnt = cnt + 4'd1;
              gate_shut = 1'b1;
              n_push++;
            end
          end else if (val == 64'd1) begin
            if (cnt == 4'd0) begin
              sts = STS_ERROR;
            end else begin
              hd = hd + 3'd1;
              cnt = cnt - 4'd1;
            end
          end else begin
            sts = STS_RETRY;
          end
        end
      end
      CMD_READ: sts = STS_RETRY;
      CMD_DONE: begin
        if (!in_flight || cnt == 4'd0) begin
          sts = STS_ERROR;
        end else begin
          hd = hd + 3'd1;
          cnt = cnt - 4'd1;
          in_flight = 1'b0;
        end
      end
      CMD_TICK: gate_shut = 1'b0;
      default: sts = STS_RETRY;
    endcase
    if (sts == STS_RETRY) n_retry++;
    if (sts == STS_ERROR) n_error++;

    // status first, then the beats of a new dispatch
    disp = !in_flight && cnt != 4'd0;
    r.kind = KIND_STATUS;
    r.status = sts;
    r.target = '0;
    r.beat = '0;
    r.last = !disp;
    r.occ = cnt;
    r.push_rdy = (cnt < QDEPTH) && !gate_shut;
    replies_due.push_back(r);
    if (disp) begin
      tgt = DISPATCH_BASE | {3'b000, cmdq_word[hd][0][27:20], 20'h00000};
      for (int b = 0; b < BEATS; b++) begin
        r.kind = KIND_BEAT;
        r.status = STS_OK;
        r.target = tgt;
        r.beat = cmdq_word[hd][b];
        r.last = (b == BEATS - 1);
        replies_due.push_back(r);
      end
      in_flight = 1'b1;
      n_disp++;
    end
  endtask

  // present one word, wait until it is taken, then predict
  task automatic send_word(input logic [1:0] cmd, input logic [31:0] addr,
                           input logic [3:0] sz, input logic [63:0] d);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start      <= 1'b1;
    in_command <= cmd;
    in_address <= addr;
    in_size    <= sz;
    in_data    <= d;
    do @(posedge clk); while (busy);
    compute_replies(cmd, addr, sz, d);
    n_sent++;
  endtask

  // base register write, only with the block drained
  task automatic write_base(input logic [31:0] v);
    start <= 1'b0;
    while (replies_due.size() != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    win_base = v;
  endtask

  // rejected and erroneous accesses: bad command, address, size or control value
  task automatic test_rejects();
    send_word(CMD_READ, win_base + CTL, 4'd1, 64'd0);
    send_word(CMD_WRITE, win_base - 32'd1, 4'd1, 64'hFF);
    send_word(CMD_WRITE, win_base, 4'd0, 64'h55);
    send_word(CMD_WRITE, win_base, 4'd15, 64'h55);
    send_word(CMD_WRITE, win_base + CTL - 4, 4'd8, 64'd0);
    send_word(CMD_WRITE, win_base + WIN_BYTES - 4, 4'd8, 64'd0);
    send_word(CMD_WRITE, win_base + WIN_BYTES, 4'd1, 64'd0);
    send_word(CMD_WRITE, win_base + CTL, 4'd8, 64'd2);
    // pop on empty queue, bytes above size ignored
    send_word(CMD_WRITE, win_base + CTL, 4'd4, 64'hFFFF_FFFF_0000_0001);
    // completion with nothing in flight
    send_word(CMD_DONE, 32'hFFFF_FFFF, 4'd15, '1);
  endtask

  // staging, push gate, pop during dispatch, completion on empty queue
  task automatic test_push_pop();
    send_word(CMD_WRITE, win_base, 4'd8, '1);
    send_word(CMD_WRITE, win_base, 4'd4, {$urandom, $urandom});
    send_word(CMD_WRITE, win_base + CTL - 1, 4'd1, 64'hA5);
    send_word(CMD_WRITE, win_base + WIN_BYTES - 1, 4'd1, 64'hFFFF_FFFF_FFFF_FF00);
    send_word(CMD_WRITE, win_base + CTL, 4'd8, 64'd0);
    send_word(CMD_TICK, 32'd0, 4'd0, 64'd0);
    send_word(CMD_WRITE, win_base + CTL + 1, 4'd2, 64'd0);
    send_word(CMD_WRITE, win_base + CTL, 4'd8, 64'd1);
    send_word(CMD_DONE, 32'd0, 4'd0, 64'd0);
    send_word(CMD_TICK, 32'd0, 4'd0, 64'd0);
    send_word(CMD_WRITE, win_base + CTL, 4'd1, 64'd0);
    send_word(CMD_WRITE, win_base + CTL, 4'd1, 64'd1);
    // in-flight mark kept but queue empty
    send_word(CMD_DONE, 32'd0, 4'd0, 64'd0);
  endtask

  // fill to depth, then a push against a full queue
  task automatic test_queue_full();
    repeat (QDEPTH) begin
      send_word(CMD_TICK, $urandom, 4'd0, 64'd0);
      send_word(CMD_WRITE, win_base + CTL, 4'd8, 64'd0);
    end
    send_word(CMD_TICK, $urandom, 4'd0, 64'd0);
    send_word(CMD_WRITE, win_base + CTL, 4'd8, 64'd0);
  endtask

  // mostly well-formed traffic with random content, some noise
  task automatic send_random_word();
    int unsigned pick;
    int unsigned off;
    int unsigned sz;
    logic [63:0] d;
    pick = $urandom_range(99);
    d = {$urandom, $urandom};
    sz = $urandom_range(1, 8);
    if (pick < 40) begin
      off = $urandom_range(CTL - 1);
      if (off + sz > CTL && $urandom_range(3) != 0) sz = CTL - off;
      send_word(CMD_WRITE, win_base + off, 4'(sz), d);
    end else if (pick < 56) begin
      off = CTL + $urandom_range(CTL - sz);
      send_word(CMD_WRITE, win_base + off, 4'(sz), d << (8 * sz));
    end else if (pick < 66) begin
      send_word(CMD_TICK, $urandom, 4'($urandom_range(15)), d);
    end else if (pick < 79) begin
      send_word(CMD_DONE, $urandom, 4'($urandom_range(15)), d);
    end else if (pick < 85) begin
      off = CTL + $urandom_range(CTL - sz);
      send_word(CMD_WRITE, win_base + off, 4'(sz), (d << (8 * sz)) | 64'd1);
    end else if (pick < 90) begin
      off = CTL + $urandom_range(CTL - sz);
      send_word(CMD_WRITE, win_base + off, 4'(sz), d);
    end else begin
      send_word(2'($urandom_range(3)),
                $urandom_range(1) ? win_base - 32'd8 + $urandom_range(80) : $urandom,
                4'($urandom_range(15)), d);
    end
  endtask

  task automatic test_random_traffic(input int n, input logic [31:0] base, input int pct);
    write_base(base);
    idle_pct = pct;
    repeat (n) send_random_word();
  endtask

  task automatic check_field(input string fname, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // compare each result word with the oldest prediction
  always @(posedge clk) begin : result_check
    reply_t e;
    if (rst_n && out_valid) begin
      if (replies_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d status %0d",
                 $time, out_kind, out_status);
        err_cnt++;
      end else begin
        e = replies_due[0];
        replies_due.delete(0);
        n_checked++;
        check_field("kind", 64'(e.kind), 64'(out_kind));
        check_field("status", 64'(e.status), 64'(out_status));
        check_field("dest_addr", 64'(e.target), 64'(out_dest_addr));
        check_field("beat_data", e.beat, out_beat_data);
        check_field("last", 64'(e.last), 64'(out_last));
        check_field("occupancy", 64'(e.occ), 64'(out_occupancy));
        check_field("push_ready", 64'(e.push_rdy), 64'(out_push_ready));
      end
    end
  end

  // no word taken or produced for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, replies_due.size());
      $display("mmio_command_queue regression: fail");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  // test sequence
  initial begin
    for (int k = 0; k < CMD_BYTES_DEF; k++) stg_byte[k] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    idle_pct = 13;
    write_base(32'h0000_0100);
    test_rejects();
    test_push_pop();
    test_queue_full();
    test_random_traffic(170, $urandom, 13);
    test_random_traffic(170, 32'hFFFF_FFC0, 72);
    test_random_traffic(25, 32'hFFFF_FFFF, 72);
    test_random_traffic(170, 32'h0000_0000, 0);
    start <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d words and %0d result words: %0d pushes, %0d dispatches",
             n_sent, n_checked, n_push, n_disp);
    $display("%0d retry and %0d error statuses across five window bases, %0d mismatches",
             n_retry, n_error, err_cnt);
    if (err_cnt == 0 && replies_due.size() == 0) begin
      $display("mmio_command_queue regression: pass");
    end else begin
      $display("mmio_command_queue regression: fail");
    end
    $finish;
  end

endmodule
